@@ hdl/aplf_pkg.sv @@
package aplf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int LAG_W      = 13;
  localparam int OUT_LAG_W  = 12;
  localparam int SUM_W      = 62;
  localparam int MIN_LAG_W  = 12;
  localparam int MAX_LAG_W  = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG = 1'd1;

  localparam logic [MIN_LAG_W-1:0] MIN_LAG_RST = 12'd44;
  localparam logic [MAX_LAG_W-1:0] MAX_LAG_RST = 13'd2646;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic search_start;
    logic lag_start;
    logic issue;
    logic compare;
    logic publish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic lag_done;
    logic lag_empty;
    logic issue_last;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/aplf_ram.sv @@
module aplf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hdl/aplf_ctrl.sv @@
module aplf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  aplf_pkg::sts_t sts,
  output aplf_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_LOAD    = 6'b000001,
    ST_LAG     = 6'b000010,
    ST_ISSUE   = 6'b000100,
    ST_DRAIN   = 6'b001000,
    ST_CMP     = 6'b010000,
    ST_PUBLISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.search_start = 1'b1;
            state_nxt        = ST_LAG;
          end
        end
      end
      ST_LAG: begin
        cmd.lag_start = 1'b1;
        if (sts.lag_done) begin
          state_nxt = ST_PUBLISH;
        end else if (sts.lag_empty) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_LAG;
      end
      ST_PUBLISH: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

@@ hdl/aplf_dp.sv @@
module aplf_dp #(
  parameter int MAX_WINDOW = 16384,
  parameter int MAX_LAG    = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  aplf_pkg::cmd_t                       cmd,
  output aplf_pkg::sts_t                       sts,
  input  logic signed [aplf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 cfg_we,
  input  logic [aplf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aplf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [aplf_pkg::OUT_LAG_W-1:0]       out_best_lag,
  output logic signed [aplf_pkg::SUM_W-1:0]    out_best_sum,
  output logic                                 out_truncated
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int LW    = aplf_pkg::LAG_W;
  localparam int XW    = (CW > LW ? CW : LW) + 1;
  localparam int ACC_W = AW + aplf_pkg::PROD_W;
  localparam logic signed [ACC_W-1:0] BEST_INIT = {{(ACC_W - 46){1'b1}}, 46'b0};

  logic [aplf_pkg::MIN_LAG_W-1:0] min_lag_r;
  logic [aplf_pkg::MAX_LAG_W-1:0] max_lag_r;
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [LW-1:0]                  lag_r, lag_nxt;
  logic [LW-1:0]                  lag_end;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [XW-1:0]                  addr_b_full;
  logic                           issue_d1_r, v2_r;
  logic signed [aplf_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [ACC_W-1:0]        best_sum_r, best_sum_nxt;
  logic [LW-1:0]                  best_lag_r, best_lag_nxt;
  logic signed [63:0]             best_sum_wide;
  logic                           out_valid_r, out_valid_nxt;
  logic [aplf_pkg::OUT_LAG_W-1:0] out_lag_r;
  logic signed [aplf_pkg::SUM_W-1:0] out_sum_r;
  logic                           out_trunc_r;
  logic                           store_we;
  logic signed [aplf_pkg::SAMPLE_W-1:0] rd_a, rd_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lag_r <= aplf_pkg::MIN_LAG_RST;
      max_lag_r <= aplf_pkg::MAX_LAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        aplf_pkg::CFG_MIN_LAG: min_lag_r <= cfg_data[aplf_pkg::MIN_LAG_W-1:0];
        aplf_pkg::CFG_MAX_LAG: max_lag_r <= cfg_data[aplf_pkg::MAX_LAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the search end to the lag limit
  always_comb begin
    if (int'(max_lag_r) > MAX_LAG) begin
      lag_end = LW'(MAX_LAG);
    end else begin
      lag_end = LW'(max_lag_r);
    end
  end

  assign store_we    = cmd.load && (count_r < CW'(MAX_WINDOW));
  assign addr_b_full = XW'(idx_r) + XW'(lag_r);

  aplf_ram #(
    .WIDTH (aplf_pkg::SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (count_r[AW-1:0]),
    .wdata   (in_sample),
    .raddr_a (idx_r[AW-1:0]),
    .rdata_a (rd_a),
    .raddr_b (addr_b_full[AW-1:0]),
    .rdata_b (rd_b)
  );

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    lag_nxt       = lag_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    best_sum_nxt  = best_sum_r;
    best_lag_nxt  = best_lag_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      if (store_we) begin
        count_nxt = count_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.search_start) begin
      lag_nxt      = LW'(min_lag_r);
      best_sum_nxt = BEST_INIT;
      best_lag_nxt = '0;
    end
    if (cmd.lag_start) begin
      idx_nxt = '0;
      acc_nxt = '0;
    end
    if (cmd.issue) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (v2_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
    if (cmd.compare) begin
      if (acc_r > best_sum_r) begin
        best_sum_nxt = acc_r;
        best_lag_nxt = lag_r;
      end
      lag_nxt = lag_r + LW'(1);
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
      count_nxt     = '0;
      ovf_nxt       = 1'b0;
    end
  end

  assign best_sum_wide = 64'(best_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      issue_d1_r  <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      issue_d1_r  <= cmd.issue;
      v2_r        <= issue_d1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lag_r      <= lag_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    best_sum_r <= best_sum_nxt;
    best_lag_r <= best_lag_nxt;
    prod_r     <= rd_a * rd_b;
    if (cmd.publish) begin
      out_lag_r   <= best_lag_r[aplf_pkg::OUT_LAG_W-1:0];
      out_sum_r   <= best_sum_wide[aplf_pkg::SUM_W-1:0];
      out_trunc_r <= ovf_r;
    end
  end

  assign sts.lag_done   = lag_r >= lag_end;
  assign sts.lag_empty  = XW'(lag_r) >= XW'(count_r);
  assign sts.issue_last = (addr_b_full + XW'(1)) == XW'(count_r);
  assign sts.pipe_empty = !issue_d1_r && !v2_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_best_lag  = out_lag_r;
  assign out_best_sum  = out_sum_r;
  assign out_truncated = out_trunc_r;

endmodule

@@ hdl/autocorrelation_peak_lag_finder_core.sv @@
// Load: one sample transaction per cycle into the window store while no search runs.
// Search, per lag: read pairs, a drain and a compare while the lag lies below the count, else
// the compare alone; one two-port store read and one multiply-accumulate unit serve all lags.
// Result: registered at search end once the output is free; the next window loads while it waits.
// Reset (rst_n, synchronous, active low): clears control, counts and flags and restores
// min_lag 44 and max_lag 2646; the store is not cleared, only written entries are read.
module autocorrelation_peak_lag_finder_core #(
  parameter int MAX_WINDOW = 16384,
  parameter int MAX_LAG    = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Sample input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [aplf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_last,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [aplf_pkg::OUT_LAG_W-1:0]       out_best_lag,
  output logic signed [aplf_pkg::SUM_W-1:0]    out_best_sum,
  output logic                                 out_truncated,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [aplf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aplf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // The controller steps through the lags: for each one it resets the accumulator,
  // issues one read pair per cycle (sample i and sample i+lag) while the lag lies
  // below the count, waits for the multiply-accumulate pipeline to drain, then
  // compares the sum against the best so far. A strict compare keeps the first winning lag.
  aplf_pkg::cmd_t cmd;
  aplf_pkg::sts_t sts;

  aplf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: store, address counters, multiplier, accumulator, best tracker
  // and the output register that holds the result until it is taken.
  aplf_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_LAG    (MAX_LAG)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     (in_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_best_lag  (out_best_lag),
    .out_best_sum  (out_best_sum),
    .out_truncated (out_truncated)
  );

endmodule

@@ hdl/aplf_checker.sv @@
module aplf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [aplf_pkg::OUT_LAG_W-1:0]    out_best_lag,
  input logic [aplf_pkg::SUM_W-1:0]        out_best_sum,
  input logic                              out_truncated
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_lag)
      && $stable(out_best_sum) && $stable(out_truncated))
    else $error("result changed while stalled");

  // Freeze loading once the final sample of a window is taken
  a_search_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input accepted during search");

  // A new result appears only at the end of a search
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a search");

endmodule

bind autocorrelation_peak_lag_finder_core aplf_checker u_aplf_checker (.*);

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Block sizing, kept at the core's defaults
  localparam int STORE_DEPTH = 16384;
  localparam int LAG_CAP     = 4096;

  // Longest quiet stretch is a full lag range over the longest random window;
  // allow several times that before calling the run hung.
  localparam int QUIET_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 100;
  localparam int PHASE_COUNT   = 8;

  localparam logic signed [aplf_pkg::SAMPLE_W-1:0] S_MIN =
    {1'b1, {(aplf_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [aplf_pkg::SAMPLE_W-1:0] S_MAX =
    {1'b0, {(aplf_pkg::SAMPLE_W-1){1'b1}}};
  // Starting best: -1.0 in Q2.46 product scale
  localparam longint FLOOR_SUM = -(longint'(1) << 46);

  // One expected peak report
  typedef struct {
    logic [aplf_pkg::OUT_LAG_W-1:0]    lag;
    logic signed [aplf_pkg::SUM_W-1:0] sum;
    logic                              trunc;
  } peak_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [aplf_pkg::SAMPLE_W-1:0] in_sample;
  logic                                 in_last;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [aplf_pkg::OUT_LAG_W-1:0]       out_best_lag;
  logic signed [aplf_pkg::SUM_W-1:0]    out_best_sum;
  logic                                 out_truncated;
  logic                                 cfg_we;
  logic [aplf_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [aplf_pkg::CFG_DATA_W-1:0]      cfg_data;

  // Shadow of the lag registers and of the window being loaded
  logic [aplf_pkg::MIN_LAG_W-1:0]       min_lag_r;
  logic [aplf_pkg::MAX_LAG_W-1:0]       max_lag_r;
  logic signed [aplf_pkg::SAMPLE_W-1:0] window_q[$];
  logic                                 window_overflow;

  // Peak reports still owed by the block, oldest first
  peak_t                                peak_q[$];

  int                                   idle_pct;
  int                                   stall_pct;
  int                                   fault_count;
  int                                   quiet_cycles;

  autocorrelation_peak_lag_finder_core #(
    .MAX_WINDOW (STORE_DEPTH),
    .MAX_LAG    (LAG_CAP)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_best_lag  (out_best_lag),
    .out_best_sum  (out_best_sum),
    .out_truncated (out_truncated),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: roll the stall dice every cycle, change only on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Score each result transaction against the oldest outstanding peak report
  always @(posedge clk) begin : score
    peak_t want;
    if (rst_n && out_valid && out_ready) begin
      if (peak_q.size() == 0) begin
        fault_count++;
        $display("%0t: result with nothing outstanding, lag %0d sum %0d trunc %0d",
                 $time, out_best_lag, out_best_sum, out_truncated);
      end else begin
        want = peak_q.pop_front();
        if (out_best_lag !== want.lag) begin
          fault_count++;
          $display("%0t: best_lag mismatch, expected %0d, actual %0d",
                   $time, want.lag, out_best_lag);
        end
        if (out_best_sum !== want.sum) begin
          fault_count++;
          $display("%0t: best_sum mismatch, expected %0d, actual %0d",
                   $time, want.sum, out_best_sum);
        end
        if (out_truncated !== want.trunc) begin
          fault_count++;
          $display("%0t: truncated mismatch, expected %0d, actual %0d",
                   $time, want.trunc, out_truncated);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Pick a sample: extremes, zero and small values often, otherwise full range
  function automatic logic signed [aplf_pkg::SAMPLE_W-1:0] pick_sample();
    logic signed [aplf_pkg::SAMPLE_W-1:0] v;
    v = aplf_pkg::SAMPLE_W'($urandom_range(31));
    case ($urandom_range(9))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3, 4: return v - aplf_pkg::SAMPLE_W'(16);
      default: return aplf_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  // Send one sample transaction, then fold it into the shadow window. On the final
  // sample, search the lags exactly as the block must and queue the peak report.
  task automatic push_sample(input logic signed [aplf_pkg::SAMPLE_W-1:0] s,
                             input logic lst);
    longint acc;
    longint best;
    int     n;
    int     stop;
    int     best_lag;
    peak_t  p;
    // Idle cycles before the transaction; scramble the payload while valid is low
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid  = 1'b0;
      in_sample = aplf_pkg::SAMPLE_W'($urandom());
      in_last   = 1'($urandom_range(1));
    end
    @(negedge clk);
    in_valid  = 1'b1;
    in_sample = s;
    in_last   = lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // Store full: drop the sample but remember the overflow
    if (window_q.size() < STORE_DEPTH) window_q.insert(window_q.size(), s);
    else window_overflow = 1'b1;

    if (lst) begin
      best     = FLOOR_SUM;
      best_lag = 0;
      n        = window_q.size();
      stop     = (max_lag_r > LAG_CAP) ? LAG_CAP : int'(max_lag_r);
      for (int lag = int'(min_lag_r); lag < stop; lag++) begin
        // Lag at or past the count leaves the sum empty, hence zero
        acc = 0;
        for (int i = 0; i < n - lag; i++) begin
          acc += longint'(window_q[i]) * longint'(window_q[i + lag]);
        end
        // Strictly greater: the first lag of a tie is kept
        if (acc > best) begin
          best     = acc;
          best_lag = lag;
        end
      end
      p.lag   = best_lag[aplf_pkg::OUT_LAG_W-1:0];
      p.sum   = best[aplf_pkg::SUM_W-1:0];
      p.trunc = window_overflow;
      peak_q.insert(peak_q.size(), p);
      window_q.delete();
      window_overflow = 1'b0;
    end
  endtask

  // Drop valid and hold until every peak report has come back, then let the block settle
  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (peak_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aplf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aplf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      aplf_pkg::CFG_MIN_LAG: min_lag_r = val[aplf_pkg::MIN_LAG_W-1:0];
      aplf_pkg::CFG_MAX_LAG: max_lag_r = val[aplf_pkg::MAX_LAG_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram the search range, only once the block has gone idle
  task automatic set_lags(input int mn, input int mx);
    wait_results();
    write_reg(aplf_pkg::CFG_MIN_LAG, aplf_pkg::CFG_DATA_W'(mn));
    write_reg(aplf_pkg::CFG_MAX_LAG, aplf_pkg::CFG_DATA_W'(mx));
  endtask

  // Short window under the reset range: every lag lies past the count, so lag 44 wins with 0
  task automatic test_reset_lags();
    idle_pct  = 0;
    stall_pct = 0;
    for (int k = 0; k < 3; k++) push_sample(pick_sample(), k == 2);
  endtask

  task automatic test_edge_cases();
    // Nothing beats -1.0: lag 1 sum is about -2.0
    set_lags(1, 2);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b1);
    // Lag zero included, extremes of the sample range
    set_lags(0, 4);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample('0, 1'b1);
    // Window of a single sample
    push_sample(S_MAX, 1'b1);
    // Tie between lags 1 and 2: keep the first
    idle_pct  = 27;
    stall_pct = 27;
    set_lags(1, 3);
    push_sample(aplf_pkg::SAMPLE_W'(2), 1'b0);
    push_sample(aplf_pkg::SAMPLE_W'(1), 1'b0);
    push_sample(aplf_pkg::SAMPLE_W'(2), 1'b1);
    // Empty lag range, both with equal bounds and with a zero end
    set_lags(5, 5);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b1);
    set_lags(0, 0);
    push_sample('0, 1'b1);
    // End beyond the lag limit is clamped; only lag 4095 remains
    set_lags(4095, 8191);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b1);
    // Widest legal range over a tiny window
    set_lags(0, 4096);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b1);
  endtask

  // Hold the sender until every report is back, then resume after a pause
  task automatic test_drain_hold();
    idle_pct  = 27;
    stall_pct = 27;
    set_lags(0, 12);
    for (int k = 0; k < 10; k++) push_sample(pick_sample(), k == 9);
    wait_results();
    repeat (40) @(posedge clk);
    for (int k = 0; k < 6; k++) push_sample(pick_sample(), k == 5);
  endtask

  // Random windows over several phases, each with its own idling and lag range
  task automatic test_random_phases();
    int sent;
    int len;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        3: set_lags(0, 4096);
        6: set_lags(4095, 4096);
        7: set_lags(0, 8191);
        default: set_lags($urandom_range(0, 20), $urandom_range(0, 48));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Mostly short windows, now and then a longer one
        len = ($urandom_range(15) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 20);
        for (int k = 0; k < len; k++) push_sample(pick_sample(), k == len - 1);
        sent += len;
        if ($urandom_range(7) == 0) wait_results();
      end
    end
  endtask

  initial begin
    // Every input known from time zero; reset held low, then released on a falling edge
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample       = '0;
    in_last         = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = aplf_pkg::CFG_MIN_LAG;
    cfg_data        = '0;
    min_lag_r       = aplf_pkg::MIN_LAG_RST;
    max_lag_r       = aplf_pkg::MAX_LAG_RST;
    window_overflow = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    fault_count     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_lags();
    test_edge_cases();
    test_drain_hold();
    test_random_phases();

    // Drain what is left, then give the verdict
    wait_results();
    if (fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/aplf_pkg.sv
hdl/aplf_ram.sv
hdl/aplf_ctrl.sv
hdl/aplf_dp.sv
hdl/autocorrelation_peak_lag_finder_core.sv
hdl/aplf_checker.sv
sim/tb_top.sv
